[rtl/core/gsp_pkg.sv]
// Shared types, constants and word tables for the German number speller.
// Used by the channel interfaces, the front end, the job queue and the back end.
// Depends on nothing.
package gsp_pkg;

  localparam int MAX_DIGITS = 21;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int CHAR_W     = 8;

  // Largest digit and largest two-digit tail that takes the split denominator form.
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam int TEEN_MAX   = 19;
  localparam int HUNDRED    = 100;

  // Job queue between front and back end.
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Word list of one job and the text store of one word.
  localparam int TOK_MAX    = 12;
  localparam int TOK_IDX_W  = $clog2(TOK_MAX);
  localparam int TOK_W      = 6;
  localparam int STR_BYTES  = 16;
  localparam int STR_LEN_W  = $clog2(STR_BYTES + 1);
  localparam int CPOS_W     = $clog2(STR_BYTES);

  localparam logic [CHAR_W-1:0] LAT_UUML = 8'hFC;
  localparam logic [CHAR_W-1:0] LAT_OUML = 8'hF6;

  typedef enum logic [1:0] {
    JOB_GROUP,
    JOB_CARD,
    JOB_DENOM,
    JOB_ABORT
  } job_kind_t;

  // One unit of work: a completed group, or the closing part of a number.
  typedef struct packed {
    job_kind_t   kind;
    logic [2:0]  idx;
    logic [2:0]  lead;
    logic [3:0]  h;
    logic [3:0]  t;
    logic [3:0]  u;
    logic        one_digit;
    logic        short_form;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  // Word codes. The digit words sit at codes 0 to 9.
  typedef enum logic [TOK_W-1:0] {
    TK_NULL, TK_EINS, TK_ZWEI, TK_DREI, TK_VIER,
    TK_FUENF, TK_SECHS, TK_SIEBEN, TK_ACHT, TK_NEUN,
    TK_EIN, TK_HUNDERT, TK_SPACE, TK_ZEHN, TK_ELF,
    TK_ZWOELF, TK_SECHZEHN, TK_SIEBZEHN, TK_UND, TK_ZWANZIG,
    TK_DREISSIG, TK_SECHZIG, TK_SIEBZIG, TK_ZIG, TK_TAUSEND,
    TK_MIO1, TK_MRD1, TK_BIO1, TK_BRD1, TK_TRIO1,
    TK_MION, TK_MRDN, TK_BION, TK_BRDN, TK_TRION,
    TK_STEL, TK_TEL, TK_GANZES, TK_HALB, TK_EINTEL,
    TK_ZWOTEL, TK_DRITTEL, TK_SIEBTEL, TK_ACHTEL
  } tok_t;

  typedef struct packed {
    logic [TOK_MAX-1:0][TOK_W-1:0] tok;
    logic [TOK_IDX_W-1:0]          cnt;
  } tok_list_t;

  typedef struct packed {
    logic [STR_LEN_W-1:0]      len;
    logic [8*STR_BYTES-1:0]    text;
  } tok_str_t;

  function automatic tok_str_t mk_str(input int unsigned len, input logic [8*STR_BYTES-1:0] text);
    tok_str_t s;
    s.len  = STR_LEN_W'(len);
    s.text = text;
    return s;
  endfunction

  // Text of each word, first character in the highest used byte.
  function automatic tok_str_t tok_str(input tok_t t);
    tok_str_t s;
    s = '0;
    case (t)
      TK_NULL:     s = mk_str(4, 128'("null"));
      TK_EINS:     s = mk_str(4, 128'("eins"));
      TK_ZWEI:     s = mk_str(4, 128'("zwei"));
      TK_DREI:     s = mk_str(4, 128'("drei"));
      TK_VIER:     s = mk_str(4, 128'("vier"));
      TK_FUENF:    s = mk_str(4, 128'({"f", LAT_UUML, "nf"}));
      TK_SECHS:    s = mk_str(5, 128'("sechs"));
      TK_SIEBEN:   s = mk_str(6, 128'("sieben"));
      TK_ACHT:     s = mk_str(4, 128'("acht"));
      TK_NEUN:     s = mk_str(4, 128'("neun"));
      TK_EIN:      s = mk_str(3, 128'("ein"));
      TK_HUNDERT:  s = mk_str(8, 128'(" hundert"));
      TK_SPACE:    s = mk_str(1, 128'(" "));
      TK_ZEHN:     s = mk_str(4, 128'("zehn"));
      TK_ELF:      s = mk_str(3, 128'("elf"));
      TK_ZWOELF:   s = mk_str(5, 128'({"zw", LAT_OUML, "lf"}));
      TK_SECHZEHN: s = mk_str(8, 128'("sechzehn"));
      TK_SIEBZEHN: s = mk_str(8, 128'("siebzehn"));
      TK_UND:      s = mk_str(3, 128'("und"));
      TK_ZWANZIG:  s = mk_str(7, 128'("zwanzig"));
      TK_DREISSIG: s = mk_str(8, 128'("dreissig"));
      TK_SECHZIG:  s = mk_str(7, 128'("sechzig"));
      TK_SIEBZIG:  s = mk_str(7, 128'("siebzig"));
      TK_ZIG:      s = mk_str(3, 128'("zig"));
      TK_TAUSEND:  s = mk_str(8, 128'(" tausend"));
      TK_MIO1:     s = mk_str(12, 128'("eine million"));
      TK_MRD1:     s = mk_str(14, 128'("eine milliarde"));
      TK_BIO1:     s = mk_str(12, 128'("eine billion"));
      TK_BRD1:     s = mk_str(14, 128'("eine billiarde"));
      TK_TRIO1:    s = mk_str(13, 128'("eine trillion"));
      TK_MION:     s = mk_str(10, 128'(" millionen"));
      TK_MRDN:     s = mk_str(11, 128'(" milliarden"));
      TK_BION:     s = mk_str(10, 128'(" billionen"));
      TK_BRDN:     s = mk_str(11, 128'(" billiarden"));
      TK_TRION:    s = mk_str(11, 128'(" trillionen"));
      TK_STEL:     s = mk_str(4, 128'("stel"));
      TK_TEL:      s = mk_str(3, 128'("tel"));
      TK_GANZES:   s = mk_str(7, 128'(" Ganzes"));
      TK_HALB:     s = mk_str(4, 128'("halb"));
      TK_EINTEL:   s = mk_str(6, 128'("eintel"));
      TK_ZWOTEL:   s = mk_str(6, 128'("zwotel"));
      TK_DRITTEL:  s = mk_str(7, 128'("drittel"));
      TK_SIEBTEL:  s = mk_str(7, 128'("siebtel"));
      TK_ACHTEL:   s = mk_str(6, 128'("achtel"));
      default:     s = mk_str(1, 128'(" "));
    endcase
    return s;
  endfunction

  // Character at position p of a word.
  function automatic logic [CHAR_W-1:0] tok_char(input tok_str_t s, input logic [CPOS_W-1:0] p);
    logic [STR_LEN_W-1:0] sh;
    sh = s.len - STR_LEN_W'(1) - STR_LEN_W'(p);
    return s.text[{sh[CPOS_W-1:0], 3'b000} +: CHAR_W];
  endfunction

  function automatic tok_t unit_tok(input logic [3:0] d);
    return tok_t'({2'b00, d});
  endfunction

  function automatic tok_list_t tl_add(input tok_list_t l, input tok_t t);
    l.tok[l.cnt] = t;
    l.cnt = l.cnt + TOK_IDX_W'(1);
    return l;
  endfunction

  // Cardinal words for a nonzero value of up to three digits.
  function automatic tok_list_t tl_small(input tok_list_t l, input logic [3:0] h,
                                         input logic [3:0] t, input logic [3:0] u);
    tok_list_t r;
    r = l;
    if (h != 4'd0) begin
      r = tl_add(r, (h == 4'd1) ? TK_EIN : unit_tok(h));
      r = tl_add(r, TK_HUNDERT);
      if (t == 4'd0 && u == 4'd0) return r;
      r = tl_add(r, TK_SPACE);
    end
    if (t == 4'd0) return tl_add(r, unit_tok(u));
    if (t == 4'd1) begin
      case (u)
        4'd0:    r = tl_add(r, TK_ZEHN);
        4'd1:    r = tl_add(r, TK_ELF);
        4'd2:    r = tl_add(r, TK_ZWOELF);
        4'd6:    r = tl_add(r, TK_SECHZEHN);
        4'd7:    r = tl_add(r, TK_SIEBZEHN);
        default: begin
          r = tl_add(r, unit_tok(u));
          r = tl_add(r, TK_ZEHN);
        end
      endcase
      return r;
    end
    if (u != 4'd0) begin
      r = tl_add(r, (u == 4'd1) ? TK_EIN : unit_tok(u));
      r = tl_add(r, TK_UND);
    end
    case (t)
      4'd2:    r = tl_add(r, TK_ZWANZIG);
      4'd3:    r = tl_add(r, TK_DREISSIG);
      4'd6:    r = tl_add(r, TK_SECHZIG);
      4'd7:    r = tl_add(r, TK_SIEBZIG);
      default: begin
        r = tl_add(r, unit_tok(t));
        r = tl_add(r, TK_ZIG);
      end
    endcase
    return r;
  endfunction

  // One scaled group; idx counts groups from the right.
  function automatic tok_list_t tl_group(input tok_list_t l, input logic [2:0] idx,
                                         input logic [3:0] h, input logic [3:0] t,
                                         input logic [3:0] u, input logic [2:0] lead);
    tok_list_t r;
    logic      one;
    r   = l;
    one = (h == 4'd0) && (t == 4'd0) && (u == 4'd1);
    if (h == 4'd0 && t == 4'd0 && u == 4'd0) return r;
    if (idx < lead) r = tl_add(r, TK_SPACE);
    case (idx)
      3'd0: r = tl_small(r, h, t, u);
      3'd1: begin
        r = one ? tl_add(r, TK_EIN) : tl_small(r, h, t, u);
        r = tl_add(r, TK_TAUSEND);
      end
      3'd2: r = one ? tl_add(r, TK_MIO1) : tl_add(tl_small(r, h, t, u), TK_MION);
      3'd3: r = one ? tl_add(r, TK_MRD1) : tl_add(tl_small(r, h, t, u), TK_MRDN);
      3'd4: r = one ? tl_add(r, TK_BIO1) : tl_add(tl_small(r, h, t, u), TK_BION);
      3'd5: r = one ? tl_add(r, TK_BRD1) : tl_add(tl_small(r, h, t, u), TK_BRDN);
      3'd6: r = one ? tl_add(r, TK_TRIO1) : tl_add(tl_small(r, h, t, u), TK_TRION);
      default: r = r;
    endcase
    return r;
  endfunction

  // Denominator word for a two-digit value.
  function automatic tok_list_t tl_tel(input tok_list_t l, input logic [3:0] t,
                                       input logic [3:0] u, input logic short_form);
    tok_list_t r;
    r = l;
    if (t == 4'd0) begin
      case (u)
        4'd0:    return r;
        4'd1:    return tl_add(r, short_form ? TK_GANZES : TK_EINTEL);
        4'd2:    return tl_add(r, short_form ? TK_HALB : TK_ZWOTEL);
        4'd3:    return tl_add(r, TK_DRITTEL);
        4'd7:    return tl_add(r, TK_SIEBTEL);
        4'd8:    return tl_add(r, TK_ACHTEL);
        default: r = r;
      endcase
    end
    r = tl_small(r, 4'd0, t, u);
    return tl_add(r, TK_TEL);
  endfunction

endpackage

[rtl/core/gsp_ifs.sv]
// Valid/ready channel interfaces of the German number speller.
// Depends on gsp_pkg for the field widths.
interface gsp_in_if;
  import gsp_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_value;
  logic [COUNT_W-1:0] digit_count;
  logic               denominator_mode;

  modport source (output valid, digit_value, digit_count, denominator_mode, input ready);
  modport sink   (input valid, digit_value, digit_count, denominator_mode, output ready);
endinterface

interface gsp_out_if;
  import gsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              char_valid;
  logic              text_end;

  modport source (output valid, char_code, char_valid, text_end, input ready);
  modport sink   (input valid, char_code, char_valid, text_end, output ready);
endinterface

[rtl/core/gsp_front.sv]
// Front end: takes digit items, tracks position and the open group, and
// queues one job per completed nonzero group or finished number.
// Depends on gsp_pkg and gsp_in_if.
module gsp_front (
  input  logic            clk,
  input  logic            rst_n,
  gsp_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output gsp_pkg::job_t   q_job
);
  import gsp_pkg::*;

  logic [COUNT_W-1:0] seen_r, seen_nxt;
  logic [3:0]         gt_r, gu_r;
  logic [3:0]         gt_nxt, gu_nxt;

  logic               accept;
  logic [3:0]         dv;
  logic [COUNT_W-1:0] cnt;
  logic               bad;
  logic [COUNT_W:0]   pos1;
  logic [COUNT_W-1:0] remaining;
  logic [8:0]         rem_prod, lead_prod;
  logic [2:0]         rem_div3;
  logic [COUNT_W-1:0] rem_mod3;
  logic [COUNT_W-1:0] cnt_m1;
  logic               grp_zero;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Position arithmetic: digits left, group index of the leading group.
  always_comb begin
    dv        = (in_ch.digit_value > DIGIT_MAX) ? DIGIT_MAX : in_ch.digit_value;
    cnt       = in_ch.digit_count;
    bad       = (cnt == '0) || (cnt > COUNT_W'(MAX_DIGITS));
    pos1      = {1'b0, seen_r} + (COUNT_W+1)'(1);
    remaining = ({1'b0, cnt} > pos1) ? COUNT_W'({1'b0, cnt} - pos1) : '0;
    rem_prod  = 9'(remaining) * 9'd11;
    rem_div3  = rem_prod[7:5];
    rem_mod3  = remaining - COUNT_W'(rem_div3) * COUNT_W'(3);
    cnt_m1    = cnt - COUNT_W'(1);
    lead_prod = 9'(cnt_m1) * 9'd11;
    grp_zero  = (gt_r == 4'd0) && (gu_r == 4'd0) && (dv == 4'd0);
  end

  // Job contents and state update for the item at the port.
  always_comb begin
    q_job.kind       = JOB_GROUP;
    q_job.idx        = rem_div3;
    q_job.lead       = lead_prod[7:5];
    q_job.h          = gt_r;
    q_job.t          = gu_r;
    q_job.u          = dv;
    q_job.one_digit  = (cnt == COUNT_W'(1));
    q_job.short_form = (cnt <= COUNT_W'(2));
    q_push   = 1'b0;
    seen_nxt = seen_r;
    gt_nxt   = gt_r;
    gu_nxt   = gu_r;
    if (accept) begin
      if (bad || remaining == '0) begin
        q_push     = 1'b1;
        q_job.kind = bad ? JOB_ABORT : (in_ch.denominator_mode ? JOB_DENOM : JOB_CARD);
        seen_nxt   = '0;
        gt_nxt     = 4'd0;
        gu_nxt     = 4'd0;
      end else if (rem_mod3 == '0) begin
        q_push   = !grp_zero;
        seen_nxt = pos1[COUNT_W-1:0];
        gt_nxt   = 4'd0;
        gu_nxt   = 4'd0;
      end else begin
        seen_nxt = pos1[COUNT_W-1:0];
        gt_nxt   = gu_r;
        gu_nxt   = dv;
      end
    end
  end

  // Position count and the two low digits of the open group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      gt_r   <= 4'd0;
      gu_r   <= 4'd0;
    end else begin
      seen_r <= seen_nxt;
      gt_r   <= gt_nxt;
      gu_r   <= gu_nxt;
    end
  end

endmodule

[rtl/core/gsp_queue.sv]
// Short job queue between the front and back end of the number speller.
// Depends on gsp_pkg.
module gsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gsp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output gsp_pkg::job_t pop_job,
  output logic          not_empty
);
  import gsp_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop)  rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

[rtl/core/gsp_back.sv]
// Back end: turns one job into its word list, then streams the characters
// one per cycle, unless the output stalls, through an output register.
// Depends on gsp_pkg and gsp_out_if.
module gsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  gsp_pkg::job_t q_job,
  output logic          q_pop,
  gsp_out_if.source     out_ch
);
  import gsp_pkg::*;

  back_state_t          st_r, st_nxt;
  tok_list_t            tl_r, tl_new;
  logic                 final_r;
  logic [TOK_IDX_W-1:0] ti_r;
  logic [CPOS_W-1:0]    ci_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_code_r;
  logic                 out_cv_r;
  logic                 out_end_r;

  logic                 slot_free;
  logic                 load;
  tok_str_t             cur_str;
  logic                 empty_text;
  logic                 tok_done;
  logic                 last_char;

  // Word list of the job at the queue head.
  always_comb begin
    tl_new = '0;
    case (q_job.kind)
      JOB_GROUP: tl_new = tl_group(tl_new, q_job.idx, q_job.h, q_job.t, q_job.u, q_job.lead);
      JOB_CARD: begin
        if (q_job.one_digit) tl_new = tl_add(tl_new, unit_tok(q_job.u));
        else tl_new = tl_group(tl_new, 3'd0, q_job.h, q_job.t, q_job.u, q_job.lead);
      end
      JOB_DENOM: begin
        if (q_job.short_form) begin
          tl_new = tl_tel(tl_new, q_job.t, q_job.u, 1'b1);
        end else if ((q_job.t == 4'd0 && q_job.u == 4'd0) || q_job.t >= 4'd2) begin
          tl_new = tl_group(tl_new, 3'd0, q_job.h, q_job.t, q_job.u, q_job.lead);
          tl_new = tl_add(tl_new, TK_STEL);
        end else begin
          tl_new = tl_group(tl_new, 3'd0, q_job.h, 4'd0, 4'd0, q_job.lead);
          tl_new = tl_add(tl_new, TK_SPACE);
          tl_new = tl_tel(tl_new, q_job.t, q_job.u, 1'b0);
        end
      end
      default: tl_new = '0;
    endcase
  end

  // Position within the current word list.
  always_comb begin
    slot_free  = !out_valid_r || out_ch.ready;
    cur_str    = tok_str(tok_t'(tl_r.tok[ti_r]));
    empty_text = (tl_r.cnt == '0);
    tok_done   = (STR_LEN_W'(ci_r) == cur_str.len - STR_LEN_W'(1));
    last_char  = empty_text || (tok_done && (ti_r == tl_r.cnt - TOK_IDX_W'(1)));
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid && (tl_new.cnt != '0 || q_job.kind != JOB_GROUP)) st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free && last_char) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    case (st_r)
      BK_IDLE: q_pop = q_valid;
      BK_EMIT: load  = slot_free;
      default: begin
        q_pop = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Word list, cursor and output payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      tl_r    <= tl_new;
      final_r <= (q_job.kind != JOB_GROUP);
      ti_r    <= '0;
      ci_r    <= '0;
    end else if (load) begin
      if (tok_done) begin
        ti_r <= ti_r + TOK_IDX_W'(1);
        ci_r <= '0;
      end else begin
        ci_r <= ci_r + CPOS_W'(1);
      end
    end
    if (load) begin
      out_code_r <= empty_text ? '0 : tok_char(cur_str, ci_r);
      out_cv_r   <= !empty_text;
      out_end_r  <= last_char && final_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.char_code  = out_code_r;
  assign out_ch.char_valid = out_cv_r;
  assign out_ch.text_end   = out_end_r;

`ifndef ASSERT_OFF
  // An empty result is only ever the closing result of a number.
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_cv_r |-> out_end_r && out_code_r == '0)
    else $error("empty result without text end");

  // A group job with no text never enters emission.
  a_group_has_text: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_EMIT && !final_r |-> tl_r.cnt != '0)
    else $error("empty group job in emission");

  // The word cursor stays inside the list while emitting.
  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_EMIT |-> ti_r < tl_r.cnt || tl_r.cnt == '0)
    else $error("word cursor past end of list");
`endif

endmodule

[rtl/core/german_number_speller.sv]
// Top level of the German number speller: front end, job queue, back end.
// Depends on gsp_pkg, gsp_ifs, gsp_front, gsp_queue and gsp_back.
//
// Digits arrive one per transfer, most significant first, each carrying the
// number's digit count (1 to 21) and the cardinal/denominator mode. The front
// end takes one digit per cycle as long as its four-entry job queue has room;
// a job is queued whenever a nonzero three-digit group completes or the
// number ends. The back end loads a job's word list and then sends one
// Latin-1 character per cycle while the output is not stalled, taking the
// next job only after the last character of the current one. Sustained
// throughput is set by the back end's character stream. The last transfer
// of a number has text_end set; a number with no text gives a single
// transfer with char_valid low.
module german_number_speller (
  input  logic      clk,
  input  logic      rst_n,
  gsp_in_if.sink    in_ch,
  gsp_out_if.source out_ch
);
  import gsp_pkg::*;

  job_t push_job, pop_job;
  logic push, full, pop, not_empty;

  gsp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_job  (push_job)
  );

  gsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (not_empty)
  );

  gsp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (not_empty),
    .q_job   (pop_job),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
